// File: hw/rtl/npe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npe_pkg
// Shared constants, types and helper functions of the NMEA position
// extractor: character codes, header tables, fixed widths and the
// constant-divide factors used by the conversion pipeline.
// ---------------------------------------------------------------------------
package npe_pkg;

   // Defaults of the top-level parameters
   localparam int MAX_FIELDS_DEF      = 15;
   localparam int FRACTION_DIGITS_DEF = 5;

   // Characters
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_SOUTH  = 8'h53;
   localparam logic [7:0] CHAR_WEST   = 8'h57;

   // Header matching
   localparam int HDR_LEN = 6;
   localparam int HDR_W   = 3;

   // Sentence kinds and first position field of each
   localparam logic KIND_GGA = 1'b0;
   localparam logic KIND_RMC = 1'b1;
   localparam int   BASE_GGA = 2;
   localparam int   BASE_RMC = 3;

   // Field roles counted from the first position field
   localparam int ROLE_LAT      = 0;
   localparam int ROLE_LAT_HEMI = 1;
   localparam int ROLE_LON      = 2;
   localparam int ROLE_LON_HEMI = 3;

   // Integer parts (ddmm / dddmm) and their saturation points
   localparam int INT_W       = 15;
   localparam int LAT_INT_W   = 14;
   localparam int LAT_INT_MAX = 16383;
   localparam int LON_INT_MAX = 32767;

   // Result widths and limits
   localparam int LAT_W     = 28;
   localparam int LON_W     = 29;
   localparam int LAT_LIMIT = 90000000;
   localparam int LON_LIMIT = 180000000;
   localparam int RSP_DATA_W = 64;

   // Conversion datapath widths
   localparam int POW_W   = 20;    // holds 10^6
   localparam int DEG_W   = 9;     // degrees up to 327
   localparam int REM_W   = 7;     // minutes 0..99
   localparam int NUM_W   = 27;    // scaled minutes below 1.35e8
   localparam int QUOT_W  = 21;    // minutes in microdegrees
   localparam int MICRO_W = 30;
   localparam int MICRO_DIGITS  = 6;
   localparam int MICRO_PER_DEG = 1000000;
   localparam int ROUND_HALF    = 30;

   // x/100 as (x * 5243) >> 19, exact for x below 32768
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_MUL_W = 13;
   localparam int DIV100_SHIFT = 19;
   localparam int HUNDRED      = 100;

   // x/60 as (x * 286331154) >> 34, exact for x below 1.35e8
   localparam longint DIV60_MUL = 64'd286331154;
   localparam int DIV60_MUL_W   = 29;
   localparam int DIV60_SHIFT   = 34;

   // Queue between parser and converter
   localparam int QUEUE_DEPTH = 2;

   // Coordinate number phase
   typedef enum logic [1:0] {
      PH_INT,
      PH_FRAC,
      PH_DONE
   } coord_phase_type;

   // Sideband that travels with a position through the converter
   typedef struct packed {
      logic [1:0] neg;     // bit0 south, bit1 west
      logic       kind;
   } side_type;

   // Expected header bytes
   function automatic logic [7:0] hdr_gga_char(input logic [HDR_W-1:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h24;   // $
         3'd1:    c = 8'h47;   // G
         3'd2:    c = 8'h50;   // P
         3'd3:    c = 8'h47;   // G
         3'd4:    c = 8'h47;   // G
         3'd5:    c = 8'h41;   // A
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] hdr_rmc_char(input logic [HDR_W-1:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h24;   // $
         3'd1:    c = 8'h47;   // G
         3'd2:    c = 8'h50;   // P
         3'd3:    c = 8'h52;   // R
         3'd4:    c = 8'h4D;   // M
         3'd5:    c = 8'h43;   // C
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Powers of ten up to 10^6
   function automatic logic [POW_W-1:0] pow10(input logic [2:0] n);
      logic [POW_W-1:0] p;
      unique case (n)
         3'd0:    p = POW_W'(1);
         3'd1:    p = POW_W'(10);
         3'd2:    p = POW_W'(100);
         3'd3:    p = POW_W'(1000);
         3'd4:    p = POW_W'(10000);
         3'd5:    p = POW_W'(100000);
         3'd6:    p = POW_W'(1000000);
         default: p = POW_W'(0);
      endcase
      return p;
   endfunction

endpackage

// File: hw/rtl/npe_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npe_front
// Line parser: matches the sentence header, counts fields, gathers the
// latitude/longitude digits and hemisphere letters, and at line end hands a
// complete position to the conversion queue.
// ---------------------------------------------------------------------------
module npe_front
   import npe_pkg::*;
#(
   parameter int MAX_FIELDS      = MAX_FIELDS_DEF,
   parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
   parameter int FRAC_W          = $clog2(10 ** FRACTION_DIGITS),
   parameter int JOB_W           = 2 * INT_W + 2 * FRAC_W + 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_fire,
   input  logic [7:0]       in_byte,
   output logic             push_valid,
   output logic [JOB_W-1:0] push_data
);

   localparam int FIELD_W = $clog2(MAX_FIELDS + 1);
   localparam int CNT_W   = $clog2(FRACTION_DIGITS + 1);
   localparam int PAD_W   = FRAC_W + POW_W;
   localparam int SUM_W   = INT_W + 4;

   logic [HDR_W-1:0]     hdr_prog_ff,  hdr_prog_in;
   logic [1:0]           kind_ok_ff,   kind_ok_in;
   logic [FIELD_W-1:0]   field_ff,     field_in;
   logic [LAT_INT_W-1:0] lat_int_ff,   lat_int_in;
   logic [FRAC_W-1:0]    lat_frac_ff,  lat_frac_in;
   logic [INT_W-1:0]     lon_int_ff,   lon_int_in;
   logic [FRAC_W-1:0]    lon_frac_ff,  lon_frac_in;
   logic [CNT_W-1:0]     frac_cnt_ff,  frac_cnt_in;
   logic [1:0]           hemi_ff,      hemi_in;
   logic [3:0]           present_ff,   present_in;
   coord_phase_type      phase_ff,     phase_in;

   logic               is_eol, is_comma, is_dot, is_digit;
   logic [3:0]         digit;
   logic               hdr_done, kind, in_body, active, coord_byte, sel_lon;
   logic [FIELD_W-1:0] base, role;
   logic               take_int, take_frac;
   logic [INT_W-1:0]   cur_int, int_max, int_new;
   logic [SUM_W-1:0]   int_sum;
   logic [FRAC_W-1:0]  cur_frac, frac_new, pad_src, pad_val;
   logic [POW_W-1:0]   pad_mul;
   logic [PAD_W-1:0]   pad_prod;

   // Byte classes
   assign is_eol   = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
   assign is_comma = (in_byte == CHAR_COMMA);
   assign is_dot   = (in_byte == CHAR_DOT);
   assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
   assign digit    = 4'(in_byte - CHAR_ZERO);

   // Position in the line
   assign hdr_done   = (hdr_prog_ff == HDR_W'(HDR_LEN));
   assign kind       = kind_ok_ff[1];
   assign base       = kind ? FIELD_W'(BASE_RMC) : FIELD_W'(BASE_GGA);
   assign in_body    = (field_ff >= base);
   assign role       = field_ff - base;
   assign active     = in_fire && !is_eol && (kind_ok_ff != 2'b00) && hdr_done;
   assign sel_lon    = (role == FIELD_W'(ROLE_LON));
   assign coord_byte = active && !is_comma && in_body &&
                       ((role == FIELD_W'(ROLE_LAT)) || sel_lon);

   // Coordinate phase: next state
   always_comb begin
      phase_in = phase_ff;
      if (in_fire && is_eol) begin
         phase_in = PH_INT;
      end else if (active && is_comma) begin
         phase_in = PH_INT;
      end else if (coord_byte) begin
         unique case (phase_ff)
            PH_INT: begin
               if (is_digit) phase_in = PH_INT;
               else if (is_dot) phase_in = PH_FRAC;
               else phase_in = PH_DONE;
            end
            PH_FRAC: begin
               if (!is_digit) phase_in = PH_DONE;
            end
            PH_DONE: phase_in = PH_DONE;
            default: phase_in = PH_DONE;
         endcase
      end
   end

   // Coordinate phase: digit actions
   always_comb begin
      take_int  = 1'b0;
      take_frac = 1'b0;
      unique case (phase_ff)
         PH_INT:  take_int  = coord_byte && is_digit;
         PH_FRAC: take_frac = coord_byte && is_digit &&
                              (frac_cnt_ff < CNT_W'(FRACTION_DIGITS));
         PH_DONE: ;
         default: ;
      endcase
   end

   // Digit accumulation for the selected coordinate
   assign cur_int  = sel_lon ? lon_int_ff : INT_W'(lat_int_ff);
   assign int_max  = sel_lon ? INT_W'(LON_INT_MAX) : INT_W'(LAT_INT_MAX);
   assign int_sum  = SUM_W'(cur_int) * SUM_W'(10) + SUM_W'(digit);
   assign int_new  = (int_sum > SUM_W'(int_max)) ? int_max : int_sum[INT_W-1:0];
   assign cur_frac = sel_lon ? lon_frac_ff : lat_frac_ff;
   assign frac_new = FRAC_W'(cur_frac * FRAC_W'(10) + FRAC_W'(digit));

   // Zero padding of a fraction when its field closes
   assign pad_src  = (field_ff == base) ? lat_frac_ff : lon_frac_ff;
   assign pad_mul  = pow10(3'(FRACTION_DIGITS - int'(frac_cnt_ff)));
   assign pad_prod = PAD_W'(pad_src) * PAD_W'(pad_mul);
   assign pad_val  = pad_prod[FRAC_W-1:0];

   // Parser state update
   always_comb begin
      hdr_prog_in = hdr_prog_ff;
      kind_ok_in  = kind_ok_ff;
      field_in    = field_ff;
      lat_int_in  = lat_int_ff;
      lat_frac_in = lat_frac_ff;
      lon_int_in  = lon_int_ff;
      lon_frac_in = lon_frac_ff;
      frac_cnt_in = frac_cnt_ff;
      hemi_in     = hemi_ff;
      present_in  = present_ff;
      push_valid  = 1'b0;
      if (in_fire) begin
         if (is_eol) begin
            push_valid  = hdr_done && (kind_ok_ff != 2'b00) && (present_ff == 4'hF);
            hdr_prog_in = '0;
            kind_ok_in  = 2'b11;
            field_in    = '0;
            lat_int_in  = '0;
            lat_frac_in = '0;
            lon_int_in  = '0;
            lon_frac_in = '0;
            frac_cnt_in = '0;
            hemi_in     = '0;
            present_in  = '0;
         end else if (kind_ok_ff != 2'b00) begin
            if (!hdr_done) begin
               if (in_byte != hdr_gga_char(hdr_prog_ff)) kind_ok_in[0] = 1'b0;
               if (in_byte != hdr_rmc_char(hdr_prog_ff)) kind_ok_in[1] = 1'b0;
               hdr_prog_in = hdr_prog_ff + HDR_W'(1);
            end else if (is_comma) begin
               if (field_ff == base) begin
                  lat_frac_in = pad_val;
               end else if (field_ff == base + FIELD_W'(2)) begin
                  lon_frac_in = pad_val;
               end
               if (field_ff < FIELD_W'(MAX_FIELDS)) field_in = field_ff + FIELD_W'(1);
               frac_cnt_in = '0;
            end else if (in_body) begin
               case (role)
                  FIELD_W'(ROLE_LAT): begin
                     present_in[0] = 1'b1;
                     if (take_int) lat_int_in = int_new[LAT_INT_W-1:0];
                     if (take_frac) begin
                        lat_frac_in = frac_new;
                        frac_cnt_in = frac_cnt_ff + CNT_W'(1);
                     end
                  end
                  FIELD_W'(ROLE_LAT_HEMI): begin
                     if (!present_ff[1]) begin
                        present_in[1] = 1'b1;
                        if (in_byte == CHAR_SOUTH) hemi_in[0] = 1'b1;
                     end
                  end
                  FIELD_W'(ROLE_LON): begin
                     present_in[2] = 1'b1;
                     if (take_int) lon_int_in = int_new;
                     if (take_frac) begin
                        lon_frac_in = frac_new;
                        frac_cnt_in = frac_cnt_ff + CNT_W'(1);
                     end
                  end
                  FIELD_W'(ROLE_LON_HEMI): begin
                     if (!present_ff[3]) begin
                        present_in[3] = 1'b1;
                        if (in_byte == CHAR_WEST) hemi_in[1] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   // Position handed to the converter; top bits follow side_type (neg, kind)
   assign push_data = {hemi_ff, kind, lon_frac_ff, lon_int_ff,
                       lat_frac_ff, INT_W'(lat_int_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_prog_ff <= '0;
         kind_ok_ff  <= 2'b11;
         field_ff    <= '0;
         lat_int_ff  <= '0;
         lat_frac_ff <= '0;
         lon_int_ff  <= '0;
         lon_frac_ff <= '0;
         frac_cnt_ff <= '0;
         hemi_ff     <= '0;
         present_ff  <= '0;
         phase_ff    <= PH_INT;
      end else begin
         hdr_prog_ff <= hdr_prog_in;
         kind_ok_ff  <= kind_ok_in;
         field_ff    <= field_in;
         lat_int_ff  <= lat_int_in;
         lat_frac_ff <= lat_frac_in;
         lon_int_ff  <= lon_int_in;
         lon_frac_ff <= lon_frac_in;
         frac_cnt_ff <= frac_cnt_in;
         hemi_ff     <= hemi_in;
         present_ff  <= present_in;
         phase_ff    <= phase_in;
      end
   end

   // Header bytes 3..5 differ between the kinds, so both cannot survive
   assert property (@(posedge clock) disable iff (reset)
      (hdr_prog_ff >= HDR_W'(4)) |-> (kind_ok_ff != 2'b11))
      else $error("npe_front: both sentence kinds matched past byte 3");

   // Header counter stops at its length
   assert property (@(posedge clock) disable iff (reset)
      hdr_prog_ff <= HDR_W'(HDR_LEN))
      else $error("npe_front: header progress overran");

endmodule

// File: hw/rtl/npe_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npe_queue
// Short first-in first-out queue that decouples the line parser from the
// conversion pipeline.
// ---------------------------------------------------------------------------
module npe_queue
   import npe_pkg::*;
#(
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] head_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // The parser only offers an item while there is room
   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("npe_queue: push into full queue");

   // Fill count follows pushes and pops
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("npe_queue: fill count lost a push");

endmodule

// File: hw/rtl/npe_conv.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npe_conv
// Conversion pipeline: ddmm.mmmm to signed microdegrees, one lane for the
// latitude and one for the longitude, constant multiplies only, with an
// output register toward the result channel.
// ---------------------------------------------------------------------------
module npe_conv
   import npe_pkg::*;
#(
   parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
   parameter int FRAC_W          = $clog2(10 ** FRACTION_DIGITS),
   parameter int JOB_W           = 2 * INT_W + 2 * FRAC_W + 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  logic [JOB_W-1:0] job_data,
   output logic             job_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [LAT_W-1:0] out_lat,
   output logic [LON_W-1:0] out_lon,
   output logic             out_kind
);

   localparam int STAGES = 6;
   localparam int LANE_W = INT_W + FRAC_W;
   localparam int D100_W = INT_W + DIV100_MUL_W;
   localparam int D60_W  = NUM_W + DIV60_MUL_W;
   localparam logic [POW_W-1:0] SCALE = pow10(3'(FRACTION_DIGITS));
   localparam logic [POW_W-1:0] TO_MICRO = pow10(3'(MICRO_DIGITS - FRACTION_DIGITS));

   logic                    adv;
   logic [STAGES-1:0]       stg_valid_ff;
   side_type                side_ff [STAGES];
   side_type                job_side;
   logic                    out_valid_ff;
   side_type                out_side_ff;
   logic [MICRO_W-1:0]      res_ff [2];

   // The whole pipeline moves unless the result register is held
   assign adv       = !out_valid_ff || out_ready;
   assign job_pop   = adv && job_valid;
   assign job_side  = job_data[2*LANE_W +: 3];

   // Valid bits and sideband
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         stg_valid_ff <= {stg_valid_ff[STAGES-2:0], job_valid};
         out_valid_ff <= stg_valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= job_side;
         for (int s = 1; s < STAGES; s++) side_ff[s] <= side_ff[s-1];
         out_side_ff <= side_ff[STAGES-1];
      end
   end

   // Two coordinate lanes
   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      localparam logic [MICRO_W-1:0] LIMIT =
         (ln == 0) ? MICRO_W'(LAT_LIMIT) : MICRO_W'(LON_LIMIT);

      logic [INT_W-1:0]   src_int;
      logic [FRAC_W-1:0]  src_frac;
      logic [D100_W-1:0]  d100_prod;
      logic [INT_W-1:0]   hund, rem_full;
      logic [D60_W-1:0]   d60_prod;
      logic [MICRO_W-1:0] sat, mag_neg;

      logic [DEG_W-1:0]   deg1_ff, deg2_ff, deg3_ff, deg4_ff, deg5_ff;
      logic [INT_W-1:0]   int1_ff;
      logic [FRAC_W-1:0]  frac1_ff, frac2_ff;
      logic [REM_W-1:0]   rem2_ff;
      logic [NUM_W-1:0]   num3_ff, m4_ff;
      logic [QUOT_W-1:0]  q5_ff;
      logic [MICRO_W-1:0] u6_ff;

      assign src_int  = job_data[ln*LANE_W +: INT_W];
      assign src_frac = job_data[ln*LANE_W + INT_W +: FRAC_W];

      // Degrees by reciprocal multiply
      assign d100_prod = D100_W'(src_int) * D100_W'(DIV100_MUL);
      // Minutes left after the degrees
      assign hund      = INT_W'(deg1_ff) * INT_W'(HUNDRED);
      assign rem_full  = int1_ff - hund;
      // Rounded divide by 60 by reciprocal multiply
      assign d60_prod  = D60_W'(m4_ff) * D60_W'(DIV60_MUL);
      // Saturate and apply hemisphere
      assign sat       = (u6_ff > LIMIT) ? LIMIT : u6_ff;
      assign mag_neg   = side_ff[STAGES-1].neg[ln] ? MICRO_W'(0) - sat : sat;

      always_ff @(posedge clock) begin
         if (adv) begin
            deg1_ff  <= d100_prod[DIV100_SHIFT +: DEG_W];
            int1_ff  <= src_int;
            frac1_ff <= src_frac;

            deg2_ff  <= deg1_ff;
            rem2_ff  <= rem_full[REM_W-1:0];
            frac2_ff <= frac1_ff;

            deg3_ff  <= deg2_ff;
            num3_ff  <= NUM_W'(rem2_ff) * NUM_W'(SCALE) + NUM_W'(frac2_ff);

            deg4_ff  <= deg3_ff;
            m4_ff    <= NUM_W'(num3_ff * NUM_W'(TO_MICRO)) + NUM_W'(ROUND_HALF);

            deg5_ff  <= deg4_ff;
            q5_ff    <= d60_prod[DIV60_SHIFT +: QUOT_W];

            u6_ff    <= MICRO_W'(deg5_ff) * MICRO_W'(MICRO_PER_DEG) + MICRO_W'(q5_ff);

            res_ff[ln] <= mag_neg;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_lat   = res_ff[0][LAT_W-1:0];
   assign out_lon   = res_ff[1][LON_W-1:0];
   assign out_kind  = out_side_ff.kind;

   // Latitude stays within +-90 degrees
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (($signed(out_lat) >= -LAT_LIMIT) && ($signed(out_lat) <= LAT_LIMIT)))
      else $error("npe_conv: latitude out of range");

   // Longitude stays within +-180 degrees
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (($signed(out_lon) >= -LON_LIMIT) && ($signed(out_lon) <= LON_LIMIT)))
      else $error("npe_conv: longitude out of range");

endmodule

// File: hw/rtl/nmea_position_extractor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nmea_position_extractor
// Extracts latitude and longitude from $GPGGA / $GPRMC sentences of an NMEA
// byte stream and reports them in signed microdegrees.
//
//   channel  dir  handshake            payload
//   req_     in   req_tvalid/tready    tdata[7:0]  rx_byte
//   rsp_     out  rsp_tvalid/tready    tdata[27:0] latitude_microdeg,
//                                      tdata[56:28] longitude_microdeg,
//                                      tuser[0] sentence_kind
//
// One byte is taken per clock cycle while req_tready is high; the parser
// updates its line state in that cycle and writes a finished position into
// the two-entry queue at the edge that takes the line end. The position is
// then offered at rsp_ after the queue, six converter stages and the result
// register. Reset clears all control state. req_tready drops only while the
// queue is full, i.e. when results back up at rsp_.
// ---------------------------------------------------------------------------
module nmea_position_extractor
   import npe_pkg::*;
#(
   parameter int MAX_FIELDS      = MAX_FIELDS_DEF,
   parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [27:0] latitude, [56:28] longitude
   output logic [0:0]            rsp_tuser    // [0] sentence kind
);

   localparam int FRAC_W = $clog2(10 ** FRACTION_DIGITS);
   localparam int JOB_W  = 2 * INT_W + 2 * FRAC_W + 3;
   localparam int PAD_W  = RSP_DATA_W - LAT_W - LON_W;

   logic             in_fire;
   logic             push_valid, queue_full;
   logic [JOB_W-1:0] push_data, head_data;
   logic             job_valid, job_pop;
   logic [LAT_W-1:0] lat;
   logic [LON_W-1:0] lon;
   logic             kind;

   assign req_tready = !queue_full;
   assign in_fire    = req_tvalid && req_tready;

   npe_front #(
      .MAX_FIELDS      (MAX_FIELDS),
      .FRACTION_DIGITS (FRACTION_DIGITS),
      .FRAC_W          (FRAC_W),
      .JOB_W           (JOB_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (in_fire),
      .in_byte    (req_tdata),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   npe_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (job_pop),
      .not_empty (job_valid),
      .head_data (head_data)
   );

   npe_conv #(
      .FRACTION_DIGITS (FRACTION_DIGITS),
      .FRAC_W          (FRAC_W),
      .JOB_W           (JOB_W)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (head_data),
      .job_pop   (job_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_lat   (lat),
      .out_lon   (lon),
      .out_kind  (kind)
   );

   assign rsp_tdata = {PAD_W'(0), lon, lat};
   assign rsp_tuser = kind;

endmodule
